/* rtl/core/pcc_pkg.sv */
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared types and constants for the conditional-integration PID controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pcc_pkg;

  localparam int DATA_W   = 32;               // Q16.16 word
  localparam int INTEG_W  = 48;               // Q32.16 integral
  localparam int MAG_W    = 48;               // operand magnitude into a gain term
  localparam int TERM_W   = 61;               // gain term magnitude, up to 2^60
  localparam int STERM_W  = TERM_W + 1;       // signed gain term
  localparam int ACC_W    = STERM_W + 1;      // sum of three signed terms
  localparam int DIV_W    = 48;               // dividend and quotient width
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam int PROD_W   = 2 * DATA_W;
  localparam int FRAC_W   = 16;
  localparam int SAT_BIT  = TERM_W - 1 - FRAC_W; // product bits above this saturate
  localparam int IDX_W    = 3;
  localparam int IN_W     = 3 * DATA_W;

  localparam logic [TERM_W-1:0] TERM_LIMIT = {1'b1, {(TERM_W-1){1'b0}}};

  localparam logic [DATA_W-1:0] LOWER_RST = 32'hFFE2_0000;
  localparam logic [DATA_W-1:0] UPPER_RST = 32'h001E_0000;

  typedef enum logic [IDX_W-1:0] {
    REG_KP    = 3'd0,
    REG_KI    = 3'd1,
    REG_KD    = 3'd2,
    REG_LOWER = 3'd3,
    REG_UPPER = 3'd4
  } pcc_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_COMB,
    ST_APPLY,
    ST_INC_MUL,
    ST_INC,
    ST_DIV_GO,
    ST_DIV,
    ST_CLAMP
  } pcc_state_t;

  typedef enum logic [1:0] {
    PH_IOLD,
    PH_P,
    PH_I,
    PH_D
  } pcc_phase_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DATA_W-1:0] divisor;
  } pcc_div_req_t;

endpackage

`default_nettype wire

/* rtl/core/pcc_mul.sv */
// ----------------------------------------------------------------------------
// pcc_mul
// Shared 32x32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_mul (
  input  wire logic                          clk,
  input  wire logic [pcc_pkg::DATA_W-1:0]    a,
  input  wire logic [pcc_pkg::DATA_W-1:0]    b,
  output logic      [pcc_pkg::PROD_W-1:0]    prod
);
  import pcc_pkg::*;

  always_ff @(posedge clk) begin
    prod <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

`default_nettype wire

/* rtl/core/pcc_div.sv */
// ----------------------------------------------------------------------------
// pcc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire pcc_pkg::pcc_div_req_t       req,
  output logic                             done,
  output logic      [pcc_pkg::DIV_W-1:0]   quotient
);
  import pcc_pkg::*;

  logic [DATA_W-1:0]    rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic [DATA_W-1:0]    dvs;
  logic [DATA_W:0]      trial;
  logic                 fits;

  // shift the next dividend bit in from the top of the quotient register
  assign trial = {rem, quotient[DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem      <= '0;
      quotient <= req.dividend;
      dvs      <= req.divisor;
    end else if (busy) begin
      rem      <= fits ? DATA_W'(trial - {1'b0, dvs}) : trial[DATA_W-1:0];
      quotient <= {quotient[DIV_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

/* rtl/core/pid_controller_conditional_integration.sv */
// ----------------------------------------------------------------------------
// pid_controller_conditional_integration
// Q16.16 PID controller with conditional integration, built around one
// shared multiplier and a serial divider under a small sequencer.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/tready         tdata: measured, target, time step
//  m_axis    out  m_axis_tvalid/tready         tdata: drive value
//  cfg       in   cfg_we (no back-pressure)    cfg_index, cfg_data
//
//  one request runs the 48-step serial divider with its start and done steps,
//  four multiplier passes, idle and clamp, plus an integral multiply and update
//  when the gate lets the integral move
//  s_axis_tready is high only while the sequencer is idle
//  the result sits in an output register; a stalled m_axis holds the sequencer
//  at its last step and a waiting result never blocks the next request
//  rst is synchronous and restores gains, limits, integral and previous error
// ----------------------------------------------------------------------------
`default_nettype none

module pid_controller_conditional_integration (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // measured_value [31:0], target_value [63:32], time_step [95:64]
  input  wire logic [pcc_pkg::IN_W-1:0]    s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // drive_value [31:0]
  output logic      [pcc_pkg::DATA_W-1:0]  m_axis_tdata,
  input  wire logic                        cfg_we,
  input  wire logic [pcc_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [pcc_pkg::DATA_W-1:0]  cfg_data
);
  import pcc_pkg::*;

  pcc_state_t state, state_next;
  pcc_phase_t phase;

  logic [DATA_W-1:0]         kp, ki, kd;
  logic signed [DATA_W-1:0]  lower, upper;
  logic signed [INTEG_W-1:0] integ;
  logic signed [DATA_W-1:0]  prev_err;

  logic signed [DATA_W-1:0]  err;
  logic [DATA_W-1:0]         dt;
  logic [MAG_W-1:0]          mag;
  logic                      neg;
  logic [PROD_W-1:0]         plo;
  logic [TERM_W-1:0]         qmag;
  logic signed [ACC_W-1:0]   acc;
  logic [DIV_W-1:0]          dmag;
  logic                      dneg;

  logic [DATA_W-1:0]         mul_a, mul_b, gain;
  logic [PROD_W-1:0]         prod;
  pcc_div_req_t              div_req;
  logic                      div_start;
  logic                      div_done;
  logic [DIV_W-1:0]          quotient;

  logic                      accept, out_go, gate;
  logic [DATA_W:0]           diff_in;
  logic [DATA_W-1:0]         err_in;
  logic [DATA_W-1:0]         err_mag;
  logic [MAG_W-1:0]          integ_mag;
  logic [DATA_W:0]           delta;
  logic [DATA_W:0]           delta_neg;
  logic                      rnd;
  logic [TERM_W-1:0]         q_sum, q_next;
  logic signed [STERM_W-1:0] term;
  logic signed [STERM_W-1:0] lower_t, upper_t;
  logic [INTEG_W:0]          inc;
  logic signed [INTEG_W+1:0] isum;
  logic signed [INTEG_W-1:0] isum_sat;
  logic signed [ACC_W-1:0]   lower_a, upper_a, clamped;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign out_go = !m_axis_tvalid || m_axis_tready;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      kp    <= '0;
      ki    <= '0;
      kd    <= '0;
      lower <= LOWER_RST;
      upper <= UPPER_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KP:    kp    <= cfg_data;
        REG_KI:    ki    <= cfg_data;
        REG_KD:    kd    <= cfg_data;
        REG_LOWER: lower <= cfg_data;
        REG_UPPER: upper <= cfg_data;
        default:   ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (accept) state_next = ST_MUL_LO;
      ST_MUL_LO:  state_next = ST_MUL_HI;
      ST_MUL_HI:  state_next = ST_COMB;
      ST_COMB:    state_next = ST_APPLY;
      ST_APPLY: begin
        unique case (phase)
          PH_IOLD: state_next = gate ? ST_INC_MUL : ST_DIV_GO;
          PH_P,
          PH_I:    state_next = ST_MUL_LO;
          PH_D:    state_next = ST_CLAMP;
          default: state_next = ST_IDLE;
        endcase
      end
      ST_INC_MUL: state_next = ST_INC;
      ST_INC:     state_next = ST_DIV_GO;
      ST_DIV_GO:  state_next = ST_DIV;
      ST_DIV:     if (div_done) state_next = ST_MUL_LO;
      ST_CLAMP:   if (out_go) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready    = 1'b0;
    div_start        = 1'b0;
    mul_a            = mag[DATA_W-1:0];
    mul_b            = gain;
    unique case (state)
      ST_IDLE:    s_axis_tready = 1'b1;
      ST_MUL_HI:  mul_a = DATA_W'(mag[MAG_W-1:DATA_W]);
      ST_INC_MUL: begin
        mul_a = err_mag;
        mul_b = dt;
      end
      ST_DIV_GO:  div_start = 1'b1;
      default:    ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    unique case (phase)
      PH_P:    gain = kp;
      PH_D:    gain = kd;
      default: gain = ki;
    endcase
  end

  pcc_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  pcc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (quotient)
  );

  // error from the incoming request, saturated to 32 bits
  always_comb begin
    diff_in = {s_axis_tdata[2*DATA_W-1], s_axis_tdata[2*DATA_W-1:DATA_W]}
            - {s_axis_tdata[DATA_W-1], s_axis_tdata[DATA_W-1:0]};
    if (diff_in[DATA_W] != diff_in[DATA_W-1])
      err_in = diff_in[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    else
      err_in = diff_in[DATA_W-1:0];
  end

  assign err_mag   = err[DATA_W-1] ? DATA_W'(-err) : err;
  assign integ_mag = integ[INTEG_W-1] ? MAG_W'(-integ) : MAG_W'(integ);

  assign delta     = {err[DATA_W-1], err} - {prev_err[DATA_W-1], prev_err};
  assign delta_neg = -delta;
  assign div_req   = '{start:    div_start,
                       dividend: {(delta[DATA_W] ? delta_neg[DATA_W-1:0]
                                                 : delta[DATA_W-1:0]),
                                  {FRAC_W{1'b0}}},
                       divisor:  dt};

  // gain term: floor(x * g / 2^16) with the magnitude capped at 2^60
  always_comb begin
    rnd    = neg && (plo[FRAC_W-1:0] != '0);
    q_sum  = {1'b0, prod[SAT_BIT-1:0], {FRAC_W{1'b0}}}
           + TERM_W'(plo[PROD_W-1:FRAC_W]) + TERM_W'(rnd);
    q_next = ((|prod[PROD_W-1:SAT_BIT]) || q_sum > TERM_LIMIT) ? TERM_LIMIT : q_sum;
  end

  assign term    = neg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
  assign lower_t = STERM_W'(lower);
  assign upper_t = STERM_W'(upper);
  assign gate    = (!err[DATA_W-1] && term <= upper_t) || (err[DATA_W-1] && term >= lower_t);

  // integral increment floor(e*dt / 2^16), sum saturated to 48 bits
  always_comb begin
    inc  = {1'b0, prod[PROD_W-1:FRAC_W]}
         + (INTEG_W+1)'(err[DATA_W-1] && (prod[FRAC_W-1:0] != '0));
    isum = (INTEG_W+2)'(integ)
         + (err[DATA_W-1] ? -$signed({1'b0, inc}) : $signed({1'b0, inc}));
    if (isum[INTEG_W+1:INTEG_W-1] == 3'b000 || isum[INTEG_W+1:INTEG_W-1] == 3'b111)
      isum_sat = isum[INTEG_W-1:0];
    else if (isum[INTEG_W+1])
      isum_sat = {1'b1, {(INTEG_W-1){1'b0}}};
    else
      isum_sat = {1'b0, {(INTEG_W-1){1'b1}}};
  end

  // lower clamp first, upper clamp wins
  always_comb begin
    lower_a = ACC_W'(lower);
    upper_a = ACC_W'(upper);
    clamped = acc;
    if (clamped < lower_a) clamped = lower_a;
    if (clamped > upper_a) clamped = upper_a;
  end

  // controller state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      integ         <= '0;
      prev_err      <= '0;
      phase         <= PH_IOLD;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (state == ST_CLAMP && out_go) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready)          m_axis_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE:  if (accept) phase <= PH_IOLD;
        ST_APPLY: begin
          unique case (phase)
            PH_P:    phase <= PH_I;
            PH_I:    phase <= PH_D;
            default: ;
          endcase
        end
        ST_INC:   integ <= isum_sat;
        ST_DIV:   if (div_done) phase <= PH_P;
        ST_CLAMP: if (out_go) prev_err <= err;
        default:  ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          err <= err_in;
          dt  <= s_axis_tdata[IN_W-1:2*DATA_W];
          mag <= integ_mag;
          neg <= integ[INTEG_W-1];
        end
      end
      ST_MUL_HI: plo  <= prod;
      ST_COMB:   qmag <= q_next;
      ST_APPLY: begin
        unique case (phase)
          PH_P: begin
            acc <= acc + ACC_W'(term);
            mag <= integ_mag;
            neg <= integ[INTEG_W-1];
          end
          PH_I: begin
            acc <= acc + ACC_W'(term);
            mag <= MAG_W'(dmag);
            neg <= dneg;
          end
          PH_D:    acc <= acc + ACC_W'(term);
          default: ;
        endcase
      end
      ST_DIV_GO: dneg <= delta[DATA_W];
      ST_DIV: begin
        if (div_done) begin
          dmag <= (dt == '0) ? '0 : quotient;
          acc  <= '0;
          mag  <= MAG_W'(err_mag);
          neg  <= err[DATA_W-1];
        end
      end
      ST_CLAMP: if (out_go) m_axis_tdata <= clamped[DATA_W-1:0];
      default:  ;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/pcc_checker.sv */
// ----------------------------------------------------------------------------
// pcc_checker
// Port-level checks for the PID controller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        s_axis_tvalid,
  input wire logic                        s_axis_tready,
  input wire logic                        m_axis_tvalid,
  input wire logic                        m_axis_tready,
  input wire logic [pcc_pkg::DATA_W-1:0]  m_axis_tdata
);
  import pcc_pkg::*;

  // a stalled result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // the sequencer is busy after taking a request
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request taken while busy");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> ##1 !$rose(m_axis_tvalid))
    else $error("result appeared too soon after request");

endmodule

bind pid_controller_conditional_integration pcc_checker u_pcc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

/* verif/tb_pid_controller_conditional_integration.sv */
// ----------------------------------------------------------------------------
// tb_pid_controller_conditional_integration
// Drives Q16.16 control samples into the PID controller under random stalls on
// both streams. Every drive value is checked against an in-bench model of the
// conditional-integration controller. Gains and limits change between phases.
// ----------------------------------------------------------------------------
module tb_pid_controller_conditional_integration;
  timeunit 1ns;
  timeprecision 1ps;

  import pcc_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] time_step;
    logic [DATA_W-1:0] target;
    logic [DATA_W-1:0] measured;
  } pid_sample_t;

  localparam logic [DATA_W-1:0] ONE = 32'h0001_0000;
  localparam logic [IDX_W-1:0] FIRST_UNUSED_REG = IDX_W'(REG_UPPER + 1);
  localparam longint ERR_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint ERR_MIN = -ERR_MAX - 1;
  localparam longint INTEG_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint INTEG_MIN = -INTEG_MAX - 1;
  localparam logic [63:0] TERM_CAP = 64'h1000_0000_0000_0000;
  localparam int WATCHDOG_LIMIT = 1000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // measured_value [31:0], target_value [63:32], time_step [95:64]
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // drive_value [31:0]
  logic [DATA_W-1:0] m_axis_tdata;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;

  pid_controller_conditional_integration dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  pid_sample_t pending_samples[$];
  logic [DATA_W-1:0] expected_drive[$];
  int mismatches = 0;
  bit idle_on = 1'b1;
  bit req_fire = 1'b0;
  int send_gap = 0;
  int stall_left = 0;
  int idle_cycles = 0;

  // model copy of the controller registers and state
  logic [DATA_W-1:0] kp, ki, kd;
  logic signed [DATA_W-1:0] lower_lim, upper_lim;
  logic signed [INTEG_W-1:0] integral_acc;
  logic signed [DATA_W-1:0] last_error;

  task automatic flag_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // floor(a * g / 2^16), magnitude capped at 2^60
  function automatic longint scale_by_gain(longint a, logic [DATA_W-1:0] g);
    logic neg;
    logic [63:0] mag;
    logic [95:0] full;
    logic [63:0] q;
    neg = a < 0;
    mag = neg ? -a : a;
    full = {32'b0, mag} * {64'b0, g};
    if (full[95:76] != 0) begin
      q = TERM_CAP;
    end else begin
      q = full[79:16];
      if (neg && full[15:0] != 0) q = q + 1;
      if (q > TERM_CAP) q = TERM_CAP;
    end
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [DATA_W-1:0] predict_drive(pid_sample_t smp);
    longint err, lo, hi, integ, iterm_old, step, dval, drive;
    logic [63:0] emag, prod, dmag;
    lo = lower_lim;
    hi = upper_lim;
    err = longint'(signed'(smp.target)) - longint'(signed'(smp.measured));
    if (err > ERR_MAX) err = ERR_MAX;
    if (err < ERR_MIN) err = ERR_MIN;
    integ = integral_acc;
    // anti-windup gate uses the integral term before this step
    iterm_old = scale_by_gain(integ, ki);
    if ((err >= 0 && iterm_old <= hi) || (err < 0 && iterm_old >= lo)) begin
      emag = (err < 0) ? -err : err;
      prod = emag * {32'b0, smp.time_step};
      step = longint'(prod >> 16);
      if (err < 0) step = (prod[15:0] != 0) ? -step - 1 : -step;
      integ = integ + step;
      if (integ > INTEG_MAX) integ = INTEG_MAX;
      if (integ < INTEG_MIN) integ = INTEG_MIN;
    end
    if (smp.time_step == 0) begin
      dval = 0;
    end else begin
      dmag = (err < last_error) ? -(err - last_error) : (err - last_error);
      dmag = (dmag << 16) / {32'b0, smp.time_step};
      dval = (err < last_error) ? -longint'(dmag) : longint'(dmag);
    end
    drive = scale_by_gain(err, kp) + scale_by_gain(integ, ki) + scale_by_gain(dval, kd);
    if (drive < lo) drive = lo;
    if (drive > hi) drive = hi;
    integral_acc = integ[INTEG_W-1:0];
    last_error = err[DATA_W-1:0];
    return drive[DATA_W-1:0];
  endfunction

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || req_fire) begin
      if (idle_on && send_gap != 0) begin
        s_axis_tvalid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_samples.size() != 0) begin
        s_axis_tdata <= pending_samples.pop_front();
        s_axis_tvalid <= 1'b1;
        if (idle_on && $urandom_range(0, 3) == 0) send_gap <= $urandom_range(1, 11);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result sink with stall bursts
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (idle_on && stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= $urandom_range(0, 10);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // monitor, model and watchdog
  always @(posedge clk) begin
    req_fire <= !rst && s_axis_tvalid && s_axis_tready;
    if (rst) begin
      kp = '0;
      ki = '0;
      kd = '0;
      lower_lim = LOWER_RST;
      upper_lim = UPPER_RST;
      integral_acc = '0;
      last_error = '0;
      idle_cycles = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_KP:    kp = cfg_data;
          REG_KI:    ki = cfg_data;
          REG_KD:    kd = cfg_data;
          REG_LOWER: lower_lim = cfg_data;
          REG_UPPER: upper_lim = cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_drive.push_back(predict_drive(s_axis_tdata));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_drive.size() == 0) begin
          flag_mismatch($sformatf("unexpected result %h", m_axis_tdata));
        end else if (m_axis_tdata !== expected_drive[0]) begin
          flag_mismatch($sformatf("drive_value got %h want %h", m_axis_tdata,
                                  expected_drive.pop_front()));
        end else begin
          void'(expected_drive.pop_front());
        end
      end
      if (cfg_we || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", idle_cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_sample(logic [DATA_W-1:0] meas, logic [DATA_W-1:0] targ,
                            logic [DATA_W-1:0] dt);
    pending_samples.push_back('{time_step: dt, target: targ, measured: meas});
  endtask

  // sender holds off until the controller has returned every drive value
  task automatic wait_until_settled();
    do @(negedge clk);
    while (pending_samples.size() != 0 || s_axis_tvalid || expected_drive.size() != 0);
    do @(negedge clk);
    while (!s_axis_tready);
  endtask

  function automatic logic [DATA_W-1:0] extreme_word();
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return 32'h0000_0001;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] random_gain();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 32'hFFFF_FFFF;
      2, 3: return $urandom_range(0, 32'h0002_0000);
      4: return $urandom;
      default: return $urandom_range(0, 32'h0000_4000);
    endcase
  endfunction

  initial begin
    int setpoint;
    int noise;
    int kind;
    logic [DATA_W-1:0] meas, targ, dt, lo_mag, hi_mag;
    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // unity P and I, quarter D, +-30.0 limits
    write_reg(REG_KP, ONE);
    write_reg(REG_KI, ONE);
    write_reg(REG_KD, 32'h0000_4000);
    write_reg(REG_LOWER, 32'hFFE2_0000);
    write_reg(REG_UPPER, 32'h001E_0000);
    end_writes();
    add_sample('0, '0, ONE);
    // +20.0 error winds the integral until the gate closes
    repeat (4) add_sample('0, 32'h0014_0000, ONE);
    // -5.0 error unwinds it
    repeat (2) add_sample('0, 32'hFFFB_0000, ONE);
    add_sample(ONE, 32'h0003_0000, '0);
    add_sample('0, 32'h0000_0001, 32'h0000_0001);
    add_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    add_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    add_sample(32'hFFFF_FFFF, '0, ONE);
    wait_until_settled();

    // lower limit above upper, plus writes to unmapped indexes
    write_reg(REG_LOWER, 32'h000A_0000);
    write_reg(REG_UPPER, 32'hFFF6_0000);
    for (int k = 0; k < 3; k++) write_reg(IDX_W'(FIRST_UNUSED_REG + k), $urandom);
    end_writes();
    add_sample(32'h0002_0000, 32'hFFFE_0000, ONE);
    add_sample($urandom, $urandom, $urandom);
    wait_until_settled();

    // full-scale gains and limits, integral runs into its 48-bit rails
    write_reg(REG_KP, 32'hFFFF_FFFF);
    write_reg(REG_KI, 32'hFFFF_FFFF);
    write_reg(REG_KD, 32'hFFFF_FFFF);
    write_reg(REG_LOWER, 32'h8000_0000);
    write_reg(REG_UPPER, 32'h7FFF_FFFF);
    end_writes();
    repeat (3) add_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    repeat (3) add_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    add_sample('0, '0, 32'h0000_0001);
    wait_until_settled();

    for (int ph = 0; ph < 8; ph++) begin
      // last two phases run without idling
      idle_on = (ph < 6) && ($urandom_range(0, 3) != 0);
      write_reg(REG_KP, random_gain());
      write_reg(REG_KI, random_gain());
      write_reg(REG_KD, random_gain());
      lo_mag = $urandom_range(32'h0001_0000, 32'h00C8_0000);
      hi_mag = $urandom_range(32'h0001_0000, 32'h00C8_0000);
      case ($urandom_range(0, 3))
        0: begin
          write_reg(REG_LOWER, 32'h8000_0000);
          write_reg(REG_UPPER, 32'h7FFF_FFFF);
        end
        1, 2: begin
          write_reg(REG_LOWER, -lo_mag);
          write_reg(REG_UPPER, hi_mag);
        end
        default: begin
          write_reg(REG_LOWER, $urandom);
          write_reg(REG_UPPER, $urandom);
        end
      endcase
      if ($urandom_range(0, 3) == 0) write_reg(IDX_W'($urandom_range(5, 7)), $urandom);
      end_writes();
      setpoint = int'($urandom_range(0, 32'h00C8_0000)) - 32'sh0064_0000;
      for (int n = 0; n < 50; n++) begin
        kind = $urandom_range(0, 19);
        meas = $urandom;
        targ = $urandom;
        dt = $urandom;
        if (kind == 0) begin
          dt = '0;
        end else if (kind == 1) begin
          meas = extreme_word();
          targ = extreme_word();
          dt = extreme_word();
        end else if (kind >= 5) begin
          // plant output tracking the setpoint, sensor-rate time step
          if ($urandom_range(0, 15) == 0) begin
            setpoint = int'($urandom_range(0, 32'h00C8_0000)) - 32'sh0064_0000;
          end
          noise = int'($urandom_range(0, 32'h0064_0000)) - 32'sh0032_0000;
          meas = setpoint + noise;
          targ = setpoint;
          dt = $urandom_range(65, 6554);
        end
        add_sample(meas, targ, dt);
      end
      wait_until_settled();
    end

    idle_on = 1'b0;
    repeat (80) @(posedge clk);
    if (expected_drive.size() != 0) begin
      flag_mismatch($sformatf("%0d drive values never arrived", expected_drive.size()));
    end
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
